FILE: rtl/core/crlc_pkg.sv
// ----------------------------------------------------------------------------
// crlc_pkg
// Shared constants for the clipboard record list checker.
// ----------------------------------------------------------------------------
package crlc_pkg;

	// number of defined clipboard formats; targets at or above never match
	localparam logic [31:0] NUM_FORMATS = 32'd3;
	// largest record count that a well formed message may carry
	localparam logic [31:0] MAX_RECORDS = 32'd1024;

	localparam int PHASE_W = 2;
	localparam int IDX_W   = 3;
	localparam int RECS_W  = 11;

	typedef logic [PHASE_W-1:0] phase_t;

	localparam phase_t PH_COUNT   = 2'd0;
	localparam phase_t PH_HEADER  = 2'd1;
	localparam phase_t PH_PAYLOAD = 2'd2;
	localparam phase_t PH_DONE    = 2'd3;

	// byte positions within the count word and the record header
	localparam logic [IDX_W:0] WORD_BYTES   = 4'd4;
	localparam logic [IDX_W:0] HEADER_BYTES = 4'd8;

endpackage

FILE: rtl/core/clipboard_record_list_checker.sv
// ----------------------------------------------------------------------------
// clipboard_record_list_checker
// Byte-serial parser that checks a marshalled clipboard record list.
// ----------------------------------------------------------------------------
// Takes one message byte per transaction and sustains one transaction per
// cycle unless stalled: each accepted byte waits in an input register, the
// parse state (phase, byte index, shift word, counters) is updated from it as
// it leaves, and the transaction flagged last loads the result register, which
// drives out_valid. The input stalls only when a last transaction meets a
// result register that is full and stalled.
// target_format may only be written while no message is in progress.
module clipboard_record_list_checker
	import crlc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       empty_message,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       well_formed,
	output logic       has_target
);

	logic [7:0]        target_q;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              empty_s1;
	logic              last_s1;

	phase_t            phase_q, phase_n;
	logic [IDX_W-1:0]  idx_q, idx_n;
	logic [31:0]       word_q, word_n;
	logic [31:0]       hdr_fmt_q, hdr_fmt_n;
	logic [RECS_W-1:0] recs_q, recs_n;
	logic [31:0]       pay_q, pay_n;
	logic              seen_q, seen_n;
	logic              err_q, err_n;

	logic              out_valid_q, wf_q, ht_q;

	logic              accept, advance;
	logic [31:0]       shifted;
	logic [IDX_W:0]    idx_inc;
	logic [RECS_W-1:0] recs_dec;
	logic [31:0]       pay_dec;
	logic              target_hit;
	logic              msg_ok;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			empty_s1 <= empty_message;
			last_s1  <= last;
		end
	end

	assign shifted  = {word_q[23:0], byte_s1};
	assign idx_inc  = {1'b0, idx_q} + 1'b1;
	assign recs_dec = recs_q - 1'b1;
	assign pay_dec  = pay_q - 1'b1;
	assign target_hit = ({24'd0, target_q} < NUM_FORMATS) &&
		(hdr_fmt_q == {24'd0, target_q});

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		word_n    = word_q;
		hdr_fmt_n = hdr_fmt_q;
		recs_n    = recs_q;
		pay_n     = pay_q;
		seen_n    = seen_q;
		err_n     = err_q;
		if (!empty_s1 && !err_q) begin
			unique case (phase_q)
				PH_COUNT: begin
					word_n = shifted;
					idx_n  = idx_inc[IDX_W-1:0];
					if (idx_inc == WORD_BYTES) begin
						idx_n = '0;
						if (shifted > MAX_RECORDS) begin
							err_n = 1'b1;
						end else begin
							recs_n  = shifted[RECS_W-1:0];
							phase_n = (shifted[RECS_W-1:0] == '0) ? PH_DONE : PH_HEADER;
						end
					end
				end
				PH_HEADER: begin
					word_n = shifted;
					idx_n  = idx_inc[IDX_W-1:0];
					if (idx_inc == WORD_BYTES) begin
						hdr_fmt_n = shifted;
					end else if (idx_inc == HEADER_BYTES) begin
						idx_n  = '0;
						recs_n = recs_dec;
						if (target_hit) begin
							seen_n = 1'b1;
						end
						if (shifted == '0) begin
							phase_n = (recs_dec == '0) ? PH_DONE : PH_HEADER;
						end else begin
							pay_n   = shifted;
							phase_n = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					pay_n = pay_dec;
					if (pay_dec == '0) begin
						phase_n = (recs_q == '0) ? PH_DONE : PH_HEADER;
					end
				end
				PH_DONE: begin
					// trailing byte after the final record
					err_n = 1'b1;
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
		end
	end

	assign msg_ok = !err_n && (phase_n == PH_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			idx_q     <= '0;
			word_q    <= '0;
			hdr_fmt_q <= '0;
			recs_q    <= '0;
			pay_q     <= '0;
			seen_q    <= 1'b0;
			err_q     <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q   <= PH_COUNT;
				idx_q     <= '0;
				word_q    <= '0;
				hdr_fmt_q <= '0;
				recs_q    <= '0;
				pay_q     <= '0;
				seen_q    <= 1'b0;
				err_q     <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				idx_q     <= idx_n;
				word_q    <= word_n;
				hdr_fmt_q <= hdr_fmt_n;
				recs_q    <= recs_n;
				pay_q     <= pay_n;
				seen_q    <= seen_n;
				err_q     <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			wf_q <= msg_ok;
			ht_q <= msg_ok && seen_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign well_formed = wf_q;
	assign has_target  = ht_q;

	a_done_no_records: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (recs_q == '0))
		else $error("all records read with records still pending");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (pay_q != '0))
		else $error("payload phase with no payload bytes due");

	a_count_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COUNT) |-> (idx_q < WORD_BYTES[IDX_W-1:0] || idx_q == '0))
		else $error("count word byte index out of range");

	a_target_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ht_q) |-> wf_q)
		else $error("target reported on malformed message");

endmodule

FILE: tb/tb_clipboard_record_list_checker.sv
// ----------------------------------------------------------------------------
// tb_clipboard_record_list_checker
// Self-checking bench for the byte-serial clipboard record list checker.
// ----------------------------------------------------------------------------
// Streams marshalled messages into the block: a few hand-built corner cases,
// then random well-formed, truncated, over-long, over-count and empty messages
// under several target_format settings. A verdict tracker mirrors the parse
// and queues the expected verdict of every message end; each verdict from the
// block is compared with the oldest one. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_clipboard_record_list_checker
	import crlc_pkg::*;
();

	typedef enum int {
		MSG_WELL,
		MSG_CUT,
		MSG_TRAIL,
		MSG_OVER,
		MSG_EMPTY
	} msg_kind_t;

	class verdict_tracker;
		typedef struct packed {
			logic wf;
			logic ht;
		} verdict_t;

		logic [7:0]       target_code;
		phase_t           cur_phase;
		logic [IDX_W:0]   byte_idx;
		logic [31:0]      shift_word;
		logic [31:0]      fmt_code;
		logic [RECS_W-1:0] recs_left;
		logic [31:0]      pay_left;
		bit               match_seen;
		bit               broken;
		verdict_t         pending[$];
		int               mismatches;

		function new();
			target_code = 8'd0;
			mismatches  = 0;
			clear_message();
		endfunction

		function void clear_message();
			cur_phase  = PH_COUNT;
			byte_idx   = '0;
			shift_word = '0;
			fmt_code   = '0;
			recs_left  = '0;
			pay_left   = '0;
			match_seen = 0;
			broken     = 0;
		endfunction

		function void set_target(logic [7:0] t);
			target_code = t;
		endfunction

		function void next_record_or_done();
			cur_phase = (recs_left == 0) ? PH_DONE : PH_HEADER;
		endfunction

		function void take_byte(logic [7:0] b);
			if (broken)
				return;
			case (cur_phase)
				PH_COUNT: begin
					shift_word = {shift_word[23:0], b};
					byte_idx++;
					if (byte_idx == WORD_BYTES) begin
						byte_idx = '0;
						if (shift_word > MAX_RECORDS)
							broken = 1;
						else begin
							recs_left = shift_word[RECS_W-1:0];
							next_record_or_done();
						end
					end
				end
				PH_HEADER: begin
					shift_word = {shift_word[23:0], b};
					byte_idx++;
					if (byte_idx == WORD_BYTES)
						fmt_code = shift_word;
					else if (byte_idx == HEADER_BYTES) begin
						byte_idx = '0;
						if ({24'd0, target_code} < NUM_FORMATS &&
						    fmt_code == {24'd0, target_code})
							match_seen = 1;
						recs_left = recs_left - 1'b1;
						if (shift_word == 0)
							next_record_or_done();
						else begin
							pay_left  = shift_word;
							cur_phase = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					pay_left--;
					if (pay_left == 0)
						next_record_or_done();
				end
				default: broken = 1;
			endcase
		endfunction

		function void note_item(logic [7:0] b, logic empty, logic ends);
			verdict_t v;
			if (!empty)
				take_byte(b);
			if (ends) begin
				v.wf = !broken && cur_phase == PH_DONE;
				v.ht = v.wf && match_seen;
				pending.push_back(v);
				clear_message();
			end
		endfunction

		task flag_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $time, what);
			mismatches++;
		endtask

		task check_verdict(logic wf, logic ht);
			verdict_t v;
			if (pending.size() == 0)
				flag_mismatch($sformatf("verdict wf=%b ht=%b with no message ended", wf, ht));
			else begin
				v = pending.pop_front();
				if (wf !== v.wf)
					flag_mismatch($sformatf("well_formed %b, expected %b", wf, v.wf));
				if (ht !== v.ht)
					flag_mismatch($sformatf("has_target %b, expected %b", ht, v.ht));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       empty_message;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic       well_formed;
	logic       has_target;

	verdict_tracker tracker;
	logic [7:0]     msg_q[$];
	bit             idle_on;
	int             items_sent;

	clipboard_record_list_checker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.empty_message (empty_message),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.well_formed   (well_formed),
		.has_target    (has_target)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(0, 99) < 25);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_verdict(well_formed, has_target);
	end

	// one transaction; called and returns at a falling edge
	task automatic send_item(input logic [7:0] b, input logic e, input logic l);
		while (idle_on && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		empty_message <= e;
		last          <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_item(b, e, l);
		if (!e || l)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		bit empty_end;
		empty_end = ($urandom_range(0, 9) == 0);
		if (msg_q.size() == 0)
			send_item(8'($urandom), 1'b1, 1'b1);
		else begin
			for (int i = 0; i < msg_q.size(); i++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(8'($urandom), 1'b1, 1'b0);
				send_item(msg_q[i], 1'b0, (i == msg_q.size() - 1) && !empty_end);
			end
			if (empty_end)
				send_item(8'($urandom), 1'b1, 1'b1);
		end
		msg_q.delete();
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			msg_q.push_back(w[i*8 +: 8]);
	endtask

	task automatic put_record(input logic [31:0] fmt, input logic [31:0] size);
		put_word(fmt);
		put_word(size);
		repeat (size)
			msg_q.push_back(8'($urandom));
	endtask

	function automatic logic [31:0] pick_format();
		case ($urandom_range(0, 9))
			6, 7: return {24'd0, tracker.target_code};
			8: return {24'd0, 8'($urandom)};
			9: return $urandom;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 19))
			0: return $urandom_range(100, 400);
			1, 2, 3: return $urandom_range(7, 40);
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	task automatic build_well();
		int unsigned n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
		put_word(n);
		repeat (n)
			put_record(pick_format(), pick_size());
	endtask

	task automatic random_message();
		int unsigned roll;
		int unsigned keep;
		logic [31:0] cnt;
		msg_kind_t   kind;
		roll = $urandom_range(0, 99);
		kind = roll < 60 ? MSG_WELL : roll < 72 ? MSG_CUT : roll < 82 ? MSG_TRAIL :
		       roll < 94 ? MSG_OVER : MSG_EMPTY;
		case (kind)
			MSG_WELL: build_well();
			MSG_CUT: begin
				if ($urandom_range(0, 1)) begin
					build_well();
					keep = $urandom_range(1, msg_q.size() - 1);
					while (msg_q.size() > keep)
						void'(msg_q.pop_back());
				end else begin
					// header claims a large payload that never arrives
					put_word($urandom_range(1, 1024));
					put_word(pick_format());
					put_word($urandom);
					repeat ($urandom_range(0, 5))
						msg_q.push_back(8'($urandom));
				end
			end
			MSG_TRAIL: begin
				build_well();
				repeat ($urandom_range(1, 3))
					msg_q.push_back(8'($urandom));
			end
			MSG_OVER: begin
				cnt = $urandom_range(0, 1) ? $urandom : $urandom_range(1025, 1100);
				if (cnt <= MAX_RECORDS)
					cnt = cnt + MAX_RECORDS + 1;
				put_word(cnt);
				repeat ($urandom_range(0, 12))
					msg_q.push_back(8'($urandom));
			end
			default: ;
		endcase
		send_message();
	endtask

	// block idle: every verdict in, then room for the pipeline to empty
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_target(input logic [7:0] t);
		cfg_we    <= 1'b1;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_target(t);
	endtask

	initial begin
		logic [7:0] tgt;
		int         phase_start;
		tracker       = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 8'd0;
		in_valid      = 1'b0;
		data_byte     = 8'd0;
		empty_message = 1'b0;
		last          = 1'b0;
		idle_on       = 1'b1;
		items_sent    = 0;
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_target(8'd1);

		// corner cases
		send_message();
		put_word(32'd0);
		msg_q.push_back(8'h00);
		send_message();
		put_word(32'd1);
		put_record(32'd1, 32'd1);
		msg_q[msg_q.size()-1] = 8'hFF;
		foreach (msg_q[i])
			send_item(msg_q[i], 1'b0, 1'b0);
		msg_q.delete();
		send_item(8'hFF, 1'b1, 1'b1);
		put_word(32'd1025);
		send_message();
		put_word(32'd1);
		put_word(32'd1);
		void'(msg_q.pop_back());
		send_message();

		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: tgt = 8'd0;
				1: tgt = 8'd2;
				2: tgt = 8'd3;
				3: tgt = 8'd255;
				4: tgt = 8'd1;
				default: tgt = 8'($urandom_range(0, 255));
			endcase
			write_target(tgt);
			idle_on = (p != 2);
			phase_start = items_sent;
			while (items_sent - phase_start < 305)
				random_message();
		end

		drain();
		repeat (8)
			@(negedge clk);
		if (tracker.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
